FILE: rtl/reservoir_latency_percentiles_defines.svh
// ----------------------------------------------------------------------------
// reservoir latency percentiles - assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RESERVOIR_LATENCY_PERCENTILES_DEFINES_SVH
`define RESERVOIR_LATENCY_PERCENTILES_DEFINES_SVH

// condition holds at every edge
`define RLP_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rlp invariant violated");

// antecedent implies consequent in the same cycle
`define RLP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlp implication violated");

// antecedent implies consequent in the next cycle
`define RLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlp sequence violated");

`endif

FILE: rtl/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// types, sizes and constants of the latency reservoir
// ----------------------------------------------------------------------------
package rlp_pkg;

  localparam int unsigned SAMPLE_DEPTH = 1024;
  localparam int unsigned ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int unsigned KEPT_W       = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned DIV_W        = 32 + KEPT_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_W + 1);
  localparam int unsigned PCT_N        = 5;
  localparam int unsigned PIDX_W       = 3;
  localparam int unsigned PERMILLE_W   = 10;
  localparam int unsigned POS_W        = PERMILLE_W + KEPT_W;
  localparam int unsigned DQ_W         = 23;

  localparam logic [30:0] RAND_MODULUS = 31'h7fffffff;
  localparam logic [31:0] SEEN_MAX     = 32'hffffffff;
  localparam logic [31:0] THOUSAND     = 32'd1000;

  // x / 1000 as (x * RCP_A) >> RCP_A_SH, exact for x below about 6.1e6
  localparam int unsigned RCP_A_SH     = 30;
  localparam logic [20:0] RCP_A        = 21'd1073742;
  // x / 125 as (x * RCP_B) >> RCP_B_SH, exact for x below 2^29
  localparam int unsigned RCP_B_SH     = 36;
  localparam logic [29:0] RCP_B        = 30'd549755814;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] sample_us;
    logic [30:0] random_word;
  } req_t;

  typedef struct packed {
    logic [10:0] count_kept;
    logic [31:0] count_seen;
    logic [31:0] min_us;
    logic [31:0] max_us;
    logic [31:0] mean_us;
    logic [31:0] p50_us;
    logic [31:0] p90_us;
    logic [31:0] p95_us;
    logic [31:0] p99_us;
    logic [31:0] p999_us;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [31:0]      remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_ST,
    S_ADD_W,
    S_SRT_RDI,
    S_SRT_LDV,
    S_SRT_RDK,
    S_SRT_CMP,
    S_SRT_PUT,
    S_SUM_RD,
    S_SUM_ACC,
    S_MEAN,
    S_MEAN_W,
    S_P_POS,
    S_P_DIV1,
    S_P_DIV1W,
    S_P_RDLO,
    S_P_RDHI,
    S_P_MUL,
    S_P_DIV2,
    S_P_DIV2W,
    S_P_REM,
    S_P_FIN,
    S_OUT
  } state_e;

  function automatic logic [PERMILLE_W-1:0] permille(input logic [PIDX_W-1:0] idx);
    logic [PERMILLE_W-1:0] val;
    unique case (idx)
      3'd0:    val = 10'd500;
      3'd1:    val = 10'd900;
      3'd2:    val = 10'd950;
      3'd3:    val = 10'd990;
      3'd4:    val = 10'd999;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/rlp_ram.sv
// ----------------------------------------------------------------------------
// rlp_ram
// sample store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rlp_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [rlp_pkg::ADDR_W-1:0] waddr_i,
  input  logic [31:0]               wdata_i,
  input  logic [rlp_pkg::ADDR_W-1:0] raddr_i,
  output logic [31:0]               rdata_o
);
  import rlp_pkg::*;

  logic [31:0] mem [SAMPLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/rlp_div.sv
// ----------------------------------------------------------------------------
// rlp_div
// restoring divider, one quotient bit per cycle, done pulses at the end
// ----------------------------------------------------------------------------
module rlp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlp_pkg::div_req_t req_i,
  output rlp_pkg::div_rsp_t rsp_o
);
  import rlp_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [32:0]          rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [31:0]          dvs_q, dvs_d;
  logic [32:0]          rem_sh;
  logic                 fits;

  assign rem_sh = {rem_q[31:0], quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_W'(DIV_W);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[31:0];

endmodule

FILE: rtl/reservoir_latency_percentiles.sv
// ----------------------------------------------------------------------------
// reservoir_latency_percentiles
// latency sample reservoir (algorithm r) with sorted percentile report
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req_i         taken when start high and busy low
//  result    done_o, res_o              one-cycle strobe, no back pressure
//
//  add while the store has room: written as it is taken, busy stays low
//  add once the store is full: busy while the
//    shared bit-serial divider computes the replacement slot
//  report: insertion sort on the single-read-port store, a read and
//    an accumulate step per entry for the sum, one divider pass for the
//    mean, then a sequence per percentile using reciprocal multiplies
//  reset clears the state and counters only; the store needs no clearing pass
//  results cannot be stalled, done_o pulses in the cycle after the last step
// ----------------------------------------------------------------------------
module reservoir_latency_percentiles (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rlp_pkg::req_t req_i,
  output logic          done_o,
  output rlp_pkg::res_t res_o
);
  import rlp_pkg::*;
  `include "reservoir_latency_percentiles_defines.svh"

  // control state
  state_e              state_q, state_d;
  logic [KEPT_W-1:0]   kept_q, kept_d;
  logic [31:0]         seen_q, seen_d;
  logic                done_q, done_d;

  // working registers
  logic [KEPT_W-1:0]   i_q, i_d;        // sort index, then sum index
  logic [KEPT_W-1:0]   k_q, k_d;        // insertion hole
  logic [31:0]         v_q, v_d;        // value being inserted
  logic [31:0]         sample_q, sample_d;
  logic [30:0]         rnd_q, rnd_d;
  logic [DIV_W-1:0]    sum_q, sum_d;
  logic [31:0]         min_q, min_d;
  logic [31:0]         max_q, max_d;
  logic [31:0]         mean_q, mean_d;
  logic [PIDX_W-1:0]   pidx_q, pidx_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ADDR_W-1:0]   lo_q, lo_d;
  logic [KEPT_W-1:0]   hi_q, hi_d;
  logic [9:0]          frac_q, frac_d;
  logic [31:0]         a_q, a_d;
  logic [31:0]         diff_q, diff_d;  // s[hi] - s[lo]
  logic [DQ_W-1:0]     dq_q, dq_d;      // diff / 1000
  logic [9:0]          dl_q, dl_d;      // diff mod 1000
  logic [31:0]         dqf_q, dqf_d;    // (diff / 1000) * frac
  logic [19:0]         prod_q, prod_d;  // (diff mod 1000) * frac
  logic [31:0]         pct_q [PCT_N];
  logic [31:0]         pct_d [PCT_N];
  res_t                res_q, res_d;

  // store and divider
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [31:0]         ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [31:0]         ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept;
  logic                full;
  logic [KEPT_W-1:0]   i_inc;
  logic [KEPT_W-1:0]   k_dec;
  logic                shift_up;
  logic [KEPT_W-1:0]   lo_ext;
  logic [KEPT_W-1:0]   lo_nx;

  // division by 1000 without the serial divider
  logic [41:0]         pos_rcp;
  logic [POS_W-1:0]    pos_rem;
  logic [58:0]         diff_rcp;
  logic [31:0]         diff_rem;
  logic [40:0]         prod_rcp;

  assign accept   = start && !busy;
  assign full     = kept_q == KEPT_W'(SAMPLE_DEPTH);
  assign i_inc    = i_q + 1'b1;
  assign k_dec    = k_q - 1'b1;
  assign shift_up = ram_rdata > v_q;
  assign lo_ext   = KEPT_W'(lo_q);
  assign lo_nx    = lo_ext + 1'b1;

  assign pos_rcp  = 42'(pos_q) * 42'(RCP_A);
  assign pos_rem  = pos_q - POS_W'(lo_q) * POS_W'(THOUSAND);
  // divide by 8 first, then by 125
  assign diff_rcp = 59'(diff_q[31:3]) * 59'(RCP_B);
  assign diff_rem = diff_q - 32'(dq_q) * THOUSAND;
  assign prod_rcp = 41'(prod_q) * 41'(RCP_A);

  rlp_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rlp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_ADD) begin
            if (full) state_d = S_ADD_ST;
          end else if (kept_q == '0) begin
            state_d = S_OUT;
          end else if (kept_q == KEPT_W'(1)) begin
            state_d = S_SUM_RD;
          end else begin
            state_d = S_SRT_RDI;
          end
        end
      end
      S_ADD_ST:  state_d = S_ADD_W;
      S_ADD_W:   if (div_rsp.done) state_d = S_IDLE;
      S_SRT_RDI: state_d = S_SRT_LDV;
      S_SRT_LDV: state_d = S_SRT_RDK;
      S_SRT_RDK: state_d = S_SRT_CMP;
      S_SRT_CMP: begin
        if (shift_up) begin
          state_d = (k_dec == '0) ? S_SRT_PUT : S_SRT_RDK;
        end else begin
          state_d = (i_inc == kept_q) ? S_SUM_RD : S_SRT_RDI;
        end
      end
      S_SRT_PUT: state_d = (i_inc == kept_q) ? S_SUM_RD : S_SRT_RDI;
      S_SUM_RD:  state_d = S_SUM_ACC;
      S_SUM_ACC: state_d = (i_inc == kept_q) ? S_MEAN : S_SUM_RD;
      S_MEAN:    state_d = S_MEAN_W;
      S_MEAN_W:  if (div_rsp.done) state_d = S_P_POS;
      S_P_POS:   state_d = S_P_DIV1;
      S_P_DIV1:  state_d = S_P_DIV1W;
      S_P_DIV1W: state_d = S_P_RDLO;
      S_P_RDLO:  state_d = S_P_RDHI;
      S_P_RDHI:  state_d = S_P_MUL;
      S_P_MUL:   state_d = S_P_DIV2;
      S_P_DIV2:  state_d = S_P_DIV2W;
      S_P_DIV2W: state_d = S_P_REM;
      S_P_REM:   state_d = S_P_FIN;
      S_P_FIN:   state_d = (pidx_q == PIDX_W'(PCT_N - 1)) ? S_OUT : S_P_POS;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath, store and divider control
  always_comb begin
    kept_d    = kept_q;
    seen_d    = seen_q;
    done_d    = 1'b0;
    i_d       = i_q;
    k_d       = k_q;
    v_d       = v_q;
    sample_d  = sample_q;
    rnd_d     = rnd_q;
    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    mean_d    = mean_q;
    pidx_d    = pidx_q;
    pos_d     = pos_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    frac_d    = frac_q;
    a_d       = a_q;
    diff_d    = diff_q;
    dq_d      = dq_q;
    dl_d      = dl_q;
    dqf_d     = dqf_q;
    prod_d    = prod_q;
    pct_d     = pct_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    div_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_ADD) begin
            seen_d   = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
            sample_d = req_i.sample_us;
            // the modulus itself reduces to slot zero
            rnd_d    = (req_i.random_word == RAND_MODULUS) ? '0 : req_i.random_word;
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = kept_q[ADDR_W-1:0];
              ram_wdata = req_i.sample_us;
              kept_d    = kept_q + 1'b1;
            end
          end else begin
            i_d    = (kept_q == KEPT_W'(1)) ? '0 : KEPT_W'(1);
            sum_d  = '0;
            min_d  = '0;
            max_d  = '0;
            mean_d = '0;
            pidx_d = '0;
            for (int p = 0; p < PCT_N; p++) pct_d[p] = '0;
          end
        end
      end
      S_ADD_ST: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(rnd_q);
        div_req.divisor  = seen_q;
      end
      S_ADD_W: begin
        // slot beyond the store drops the sample
        if (div_rsp.done && div_rsp.remainder < 32'(SAMPLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = div_rsp.remainder[ADDR_W-1:0];
          ram_wdata = sample_q;
        end
      end
      S_SRT_RDI: ram_raddr = i_q[ADDR_W-1:0];
      S_SRT_LDV: begin
        v_d = ram_rdata;
        k_d = i_q;
      end
      S_SRT_RDK: ram_raddr = k_dec[ADDR_W-1:0];
      S_SRT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[ADDR_W-1:0];
        if (shift_up) begin
          ram_wdata = ram_rdata;
          k_d       = k_dec;
        end else begin
          ram_wdata = v_q;
          i_d       = (i_inc == kept_q) ? '0 : i_inc;
        end
      end
      S_SRT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = v_q;
        i_d       = (i_inc == kept_q) ? '0 : i_inc;
      end
      S_SUM_RD:  ram_raddr = i_q[ADDR_W-1:0];
      S_SUM_ACC: begin
        sum_d = sum_q + DIV_W'(ram_rdata);
        if (i_q == '0) min_d = ram_rdata;
        if (i_inc == kept_q) max_d = ram_rdata;
        i_d = i_inc;
      end
      S_MEAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_q;
        div_req.divisor  = 32'(kept_q);
      end
      S_MEAN_W: if (div_rsp.done) mean_d = div_rsp.quotient[31:0];
      S_P_POS:  pos_d = POS_W'(permille(pidx_q)) * POS_W'(kept_q - 1'b1);
      // lo = pos / 1000
      S_P_DIV1: lo_d = pos_rcp[RCP_A_SH +: ADDR_W];
      S_P_DIV1W: begin
        frac_d = pos_rem[9:0];
        hi_d   = (lo_nx < kept_q) ? lo_nx : lo_ext;
      end
      S_P_RDLO: ram_raddr = lo_q;
      S_P_RDHI: begin
        a_d       = ram_rdata;
        ram_raddr = hi_q[ADDR_W-1:0];
      end
      S_P_MUL:  diff_d = ram_rdata - a_q;
      S_P_DIV2: dq_d = diff_rcp[RCP_B_SH +: DQ_W];
      // diff*frac/1000 = (diff/1000)*frac + ((diff mod 1000)*frac)/1000
      S_P_DIV2W: begin
        dl_d  = diff_rem[9:0];
        dqf_d = 32'(dq_q) * 32'(frac_q);
      end
      S_P_REM:  prod_d = 20'(dl_q) * 20'(frac_q);
      S_P_FIN: begin
        pct_d[pidx_q] = a_q + dqf_q + 32'(prod_rcp[RCP_A_SH +: 11]);
        pidx_d        = pidx_q + 1'b1;
      end
      S_OUT: begin
        done_d           = 1'b1;
        res_d.count_kept = 11'(kept_q);
        res_d.count_seen = seen_q;
        res_d.min_us     = min_q;
        res_d.max_us     = max_q;
        res_d.mean_us    = mean_q;
        res_d.p50_us     = pct_q[0];
        res_d.p90_us     = pct_q[1];
        res_d.p95_us     = pct_q[2];
        res_d.p99_us     = pct_q[3];
        res_d.p999_us    = pct_q[4];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kept_q  <= '0;
      seen_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kept_q  <= kept_d;
      seen_q  <= seen_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    k_q      <= k_d;
    v_q      <= v_d;
    sample_q <= sample_d;
    rnd_q    <= rnd_d;
    sum_q    <= sum_d;
    min_q    <= min_d;
    max_q    <= max_d;
    mean_q   <= mean_d;
    pidx_q   <= pidx_d;
    pos_q    <= pos_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    frac_q   <= frac_d;
    a_q      <= a_d;
    diff_q   <= diff_d;
    dq_q     <= dq_d;
    dl_q     <= dl_d;
    dqf_q    <= dqf_d;
    prod_q   <= prod_d;
    pct_q    <= pct_d;
    res_q    <= res_d;
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

  // result strobe only follows the output step
  `RLP_ASSERT_IMPL(a_done_after_out, done_q, $past(state_q == S_OUT))
  // fill count never passes the store depth
  `RLP_ASSERT_NOW(a_kept_bound, kept_q <= KEPT_W'(SAMPLE_DEPTH))
  // replacement ends the add and frees the block
  `RLP_ASSERT_NEXT(a_add_ends, state_q == S_ADD_W && div_rsp.done, state_q == S_IDLE)
  // a full-store add always runs through the divider
  `RLP_ASSERT_NEXT(a_full_add_busy, accept && req_i.req_type == REQ_ADD && full, busy)

endmodule
